/* rtl/abcs_pkg.sv */
// ----------------------------------------------------------------------------
// abcs_pkg
// Shared types, widths, register codes and reset values of the adaptive band
// copy scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package abcs_pkg;

  localparam int COORD_BITS_DEF = 14;
  localparam int KIND_W         = 2;
  localparam int ELAPSED_W      = 24;
  localparam int TARGET_W       = 16;
  localparam int OSB_W          = 14;
  localparam int BAND_W         = 9;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int DVD_W          = BAND_W + TARGET_W;

  localparam logic [TARGET_W-1:0] TARGET_RST     = 16'd1500;
  localparam logic [OSB_W-1:0]    ONE_SHOT_RST   = 14'd96;
  localparam logic [BAND_W-1:0]   START_BAND_RST = 9'd64;
  localparam logic [BAND_W-1:0]   MIN_BAND_RST   = 9'd16;
  localparam logic [BAND_W-1:0]   MAX_BAND_RST   = 9'd256;
  localparam logic [BAND_W-1:0]   STEP_FLOOR     = 9'd16;

  typedef enum logic [KIND_W-1:0] {
    KIND_BEGIN  = 2'd0,
    KIND_STEP   = 2'd1,
    KIND_TIMING = 2'd2,
    KIND_CANCEL = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET     = 3'd0,
    CFG_ONE_SHOT   = 3'd1,
    CFG_START_BAND = 3'd2,
    CFG_MIN_BAND   = 3'd3,
    CFG_MAX_BAND   = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV
  } st_t;

  typedef struct packed {
    logic [TARGET_W-1:0] chunk_target_us;
    logic [OSB_W-1:0]    one_shot_below;
    logic [BAND_W-1:0]   start_band;
    logic [BAND_W-1:0]   min_band;
    logic [BAND_W-1:0]   max_band;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/adaptive_band_copy_scheduler_core.sv */
// Begin, step, cancel and timing items with zero elapsed time or no band yet
//   give their result in the cycle after acceptance; busy stays low.
// An adapting timing item passes operand load, one divider iteration per
//   quotient bit, clamp and result, with busy high until the result; one item
//   a cycle otherwise. The result strobe lasts one cycle and cannot be stalled.
// Reset (synchronous, rst_n low) ends any job and loads register defaults.
// ----------------------------------------------------------------------------
// adaptive_band_copy_scheduler_core
// Splits a rectangle copy into row bands and adapts the band height to a
// time budget with an iterative divider.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_band_copy_scheduler_core #(
  parameter int COORD_BITS = abcs_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [abcs_pkg::KIND_W-1:0]     in_kind,
  input  logic [COORD_BITS-1:0]           in_rect_x,
  input  logic [COORD_BITS-1:0]           in_rect_y,
  input  logic [COORD_BITS-1:0]           in_rect_w,
  input  logic [COORD_BITS-1:0]           in_rect_h,
  input  logic [abcs_pkg::ELAPSED_W-1:0]  in_elapsed_us,
  output logic                            out_strobe,
  output logic                            out_copy_valid,
  output logic [COORD_BITS-1:0]           out_copy_x,
  output logic [COORD_BITS:0]             out_copy_y,
  output logic [COORD_BITS-1:0]           out_copy_w,
  output logic [COORD_BITS-1:0]           out_copy_h,
  output logic                            out_job_pending,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [abcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [abcs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import abcs_pkg::*;

  localparam int Y_W   = COORD_BITS + 1;
  localparam int CMP_W = (COORD_BITS > OSB_W) ? COORD_BITS : OSB_W;

  cfg_t cfg;

  st_t state_r, state_nxt;

  logic                  live_r, live_nxt;
  logic [COORD_BITS-1:0] job_left_r, job_left_nxt;
  logic [COORD_BITS-1:0] job_top_r, job_top_nxt;
  logic [COORD_BITS-1:0] job_width_r, job_width_nxt;
  logic [COORD_BITS-1:0] job_height_r, job_height_nxt;
  logic [COORD_BITS-1:0] rows_done_r, rows_done_nxt;
  logic [BAND_W-1:0]     band_rows_r, band_rows_nxt;
  logic [BAND_W-1:0]     last_band_r, last_band_nxt;
  logic [DVD_W-1:0]      prod_r, prod_nxt;
  logic [ELAPSED_W-1:0]  el_r, el_nxt;

  logic                  out_strobe_r, out_strobe_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [COORD_BITS-1:0] out_x_r, out_x_nxt;
  logic [Y_W-1:0]        out_y_r, out_y_nxt;
  logic [COORD_BITS-1:0] out_w_r, out_w_nxt;
  logic [COORD_BITS-1:0] out_h_r, out_h_nxt;
  logic                  out_pend_r, out_pend_nxt;

  logic                  accept;
  logic                  adapt;
  logic                  div_start;
  logic                  div_done;
  logic [DVD_W-1:0]      div_quo;

  logic                  short_rect;
  logic [BAND_W-1:0]     start_cut;
  logic [BAND_W-1:0]     floor_band;
  logic [Y_W-1:0]        step_sum;
  logic                  no_rows;
  logic                  trim;
  logic [COORD_BITS-1:0] rows_left;
  logic [BAND_W-1:0]     step_band;
  logic [COORD_BITS-1:0] step_done;
  logic                  step_live;
  logic [Y_W-1:0]        step_y;
  logic [DVD_W-1:0]      mult;
  logic [DVD_W-1:0]      clamp_lo;
  logic [DVD_W-1:0]      clamp_hi;

  abcs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  abcs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (el_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign accept    = start && (state_r == ST_IDLE);
  assign adapt     = (in_elapsed_us != '0) && (last_band_r != '0);
  assign div_start = (state_r == ST_LOAD);

  // begin item
  assign short_rect = CMP_W'(in_rect_h) < CMP_W'(cfg.one_shot_below);
  assign start_cut  = (COORD_BITS'(cfg.start_band) > in_rect_h) ?
                      in_rect_h[BAND_W-1:0] : cfg.start_band;

  // step item
  assign floor_band = (band_rows_r < STEP_FLOOR) ? STEP_FLOOR : band_rows_r;
  assign step_sum   = Y_W'(rows_done_r) + Y_W'(floor_band);
  assign no_rows    = rows_done_r >= job_height_r;
  assign trim       = step_sum > Y_W'(job_height_r);
  assign rows_left  = job_height_r - rows_done_r;
  assign step_band  = trim ? rows_left[BAND_W-1:0] : floor_band;
  assign step_done  = rows_done_r + COORD_BITS'(step_band);
  assign step_live  = !(step_done >= job_height_r);
  assign step_y     = Y_W'(job_top_r) + Y_W'(rows_done_r);

  // timing item: product, then clamp of the quotient (lower bound first)
  assign mult     = DVD_W'(last_band_r) * DVD_W'(cfg.chunk_target_us);
  assign clamp_lo = (div_quo < DVD_W'(cfg.min_band)) ? DVD_W'(cfg.min_band) : div_quo;
  assign clamp_hi = (clamp_lo > DVD_W'(cfg.max_band)) ? DVD_W'(cfg.max_band) : clamp_lo;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (kind_t'(in_kind) == KIND_TIMING) && adapt) state_nxt = ST_LOAD;
      end
      ST_LOAD: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    live_nxt       = live_r;
    job_left_nxt   = job_left_r;
    job_top_nxt    = job_top_r;
    job_width_nxt  = job_width_r;
    job_height_nxt = job_height_r;
    rows_done_nxt  = rows_done_r;
    band_rows_nxt  = band_rows_r;
    last_band_nxt  = last_band_r;
    prod_nxt       = prod_r;
    el_nxt         = el_r;
    out_strobe_nxt = 1'b0;
    out_valid_nxt  = out_valid_r;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    out_w_nxt      = out_w_r;
    out_h_nxt      = out_h_r;
    out_pend_nxt   = out_pend_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_strobe_nxt = 1'b1;
          out_valid_nxt  = 1'b0;
          out_x_nxt      = '0;
          out_y_nxt      = '0;
          out_w_nxt      = '0;
          out_h_nxt      = '0;
          out_pend_nxt   = live_r;
          case (kind_t'(in_kind))
            KIND_BEGIN: begin
              if (short_rect) begin
                out_valid_nxt = 1'b1;
                out_x_nxt     = in_rect_x;
                out_y_nxt     = Y_W'(in_rect_y);
                out_w_nxt     = in_rect_w;
                out_h_nxt     = in_rect_h;
              end else begin
                job_left_nxt   = in_rect_x;
                job_top_nxt    = in_rect_y;
                job_width_nxt  = in_rect_w;
                job_height_nxt = in_rect_h;
                rows_done_nxt  = '0;
                band_rows_nxt  = start_cut;
                last_band_nxt  = '0;
                live_nxt       = 1'b1;
                out_pend_nxt   = 1'b1;
              end
            end
            KIND_STEP: begin
              if (live_r && no_rows) begin
                live_nxt     = 1'b0;
                out_pend_nxt = 1'b0;
              end else if (live_r) begin
                rows_done_nxt = step_done;
                last_band_nxt = step_band;
                live_nxt      = step_live;
                out_pend_nxt  = step_live;
                out_valid_nxt = 1'b1;
                out_x_nxt     = job_left_r;
                out_y_nxt     = step_y;
                out_w_nxt     = job_width_r;
                out_h_nxt     = COORD_BITS'(step_band);
              end
            end
            KIND_TIMING: begin
              if (adapt) begin
                // hold the result until the divider finishes
                out_strobe_nxt = 1'b0;
                prod_nxt       = mult;
                el_nxt         = in_elapsed_us;
              end
            end
            KIND_CANCEL: begin
              live_nxt     = 1'b0;
              out_pend_nxt = 1'b0;
            end
            default: live_nxt = live_r;
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          band_rows_nxt  = clamp_hi[BAND_W-1:0];
          out_strobe_nxt = 1'b1;
          out_valid_nxt  = 1'b0;
          out_x_nxt      = '0;
          out_y_nxt      = '0;
          out_w_nxt      = '0;
          out_h_nxt      = '0;
          out_pend_nxt   = live_r;
        end
      end
      default: out_strobe_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      live_r       <= 1'b0;
      job_left_r   <= '0;
      job_top_r    <= '0;
      job_width_r  <= '0;
      job_height_r <= '0;
      rows_done_r  <= '0;
      band_rows_r  <= START_BAND_RST;
      last_band_r  <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      live_r       <= live_nxt;
      job_left_r   <= job_left_nxt;
      job_top_r    <= job_top_nxt;
      job_width_r  <= job_width_nxt;
      job_height_r <= job_height_nxt;
      rows_done_r  <= rows_done_nxt;
      band_rows_r  <= band_rows_nxt;
      last_band_r  <= last_band_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r      <= prod_nxt;
    el_r        <= el_nxt;
    out_valid_r <= out_valid_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_w_r     <= out_w_nxt;
    out_h_r     <= out_h_nxt;
    out_pend_r  <= out_pend_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_strobe      = out_strobe_r;
  assign out_copy_valid  = out_valid_r;
  assign out_copy_x      = out_x_r;
  assign out_copy_y      = out_y_r;
  assign out_copy_w      = out_w_r;
  assign out_copy_h      = out_h_r;
  assign out_job_pending = out_pend_r;

endmodule

`default_nettype wire

/* rtl/abcs_cfg.sv */
// ----------------------------------------------------------------------------
// abcs_cfg
// Configuration register bank; one register written per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module abcs_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [abcs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [abcs_pkg::CFG_DATA_W-1:0]   cfg_data,
  output abcs_pkg::cfg_t                    cfg
);
  import abcs_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TARGET:     cfg_nxt.chunk_target_us = cfg_data[TARGET_W-1:0];
        CFG_ONE_SHOT:   cfg_nxt.one_shot_below  = cfg_data[OSB_W-1:0];
        CFG_START_BAND: cfg_nxt.start_band      = cfg_data[BAND_W-1:0];
        CFG_MIN_BAND:   cfg_nxt.min_band        = cfg_data[BAND_W-1:0];
        CFG_MAX_BAND:   cfg_nxt.max_band        = cfg_data[BAND_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.chunk_target_us <= TARGET_RST;
      cfg_r.one_shot_below  <= ONE_SHOT_RST;
      cfg_r.start_band      <= START_BAND_RST;
      cfg_r.min_band        <= MIN_BAND_RST;
      cfg_r.max_band        <= MAX_BAND_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/abcs_div.sv */
// ----------------------------------------------------------------------------
// abcs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module abcs_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [abcs_pkg::DVD_W-1:0]     dividend,
  input  logic [abcs_pkg::ELAPSED_W-1:0] divisor,
  output logic                           done,
  output logic [abcs_pkg::DVD_W-1:0]     quotient
);
  import abcs_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]     quo_r, quo_nxt;
  logic [ELAPSED_W-1:0] rem_r, rem_nxt;
  logic [ELAPSED_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;

  logic [ELAPSED_W:0]   shifted;
  logic [ELAPSED_W:0]   diff;
  logic                 fits;

  assign shifted = {rem_r, quo_r[DVD_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
      cnt_nxt = CNT_W'(DVD_W);
    end else if (cnt_r != '0) begin
      // shift in the next dividend bit, subtract when it fits
      rem_nxt  = fits ? diff[ELAPSED_W-1:0] : shifted[ELAPSED_W-1:0];
      quo_nxt  = {quo_r[DVD_W-2:0], fits};
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

/* rtl/abcs_chk.sv */
// ----------------------------------------------------------------------------
// abcs_chk
// Port-level checks of the band copy scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module abcs_chk #(
  parameter int COORD_BITS = abcs_pkg::COORD_BITS_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic                            out_strobe,
  input logic                            out_copy_valid,
  input logic [COORD_BITS-1:0]           out_copy_x,
  input logic [COORD_BITS:0]             out_copy_y,
  input logic [COORD_BITS-1:0]           out_copy_w,
  input logic [COORD_BITS-1:0]           out_copy_h
);

  // every accepted transaction either answers next cycle or starts the divider
  a_accept_answers: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_strobe || busy)
    else $error("accepted transaction neither answered nor went busy");

  a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_strobe)
    else $error("result strobe while busy");

  a_busy_ends_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_strobe)
    else $error("busy dropped without a result");

  a_no_copy_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_copy_valid |->
      out_copy_x == '0 && out_copy_y == '0 && out_copy_w == '0 && out_copy_h == '0)
    else $error("copy fields nonzero without a copy");

endmodule

bind adaptive_band_copy_scheduler_core abcs_chk #(.COORD_BITS(COORD_BITS)) u_abcs_chk (.*);

`default_nettype wire
